// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the deframer RTL.
// Both macros sample on the rising edge of aclk; the first one is
// disabled while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored during reset.
`define DFDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DFDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/dfdc_pkg.sv =====
`default_nettype none

package dfdc_pkg;

    // Frame layout, in bytes.
    localparam int unsigned HDR_BYTES     = 8;
    localparam int unsigned TRAILER_BYTES = 2;
    localparam int unsigned MIN_FRAME     = HDR_BYTES + TRAILER_BYTES;

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [10:0] APID_MASK     = 11'h7FF;
    localparam logic [5:0]  NUL_HIGH_MASK = 6'h3F;

    // Byte positions that carry header fields.
    localparam logic [COUNT_W-1:0] POS_ID_LOW   = 17'd1;
    localparam logic [COUNT_W-1:0] POS_APID_LOW = 17'd3;
    localparam logic [COUNT_W-1:0] POS_GRID     = 17'd4;
    localparam logic [COUNT_W-1:0] POS_NUL_LOW  = 17'd5;
    localparam logic [COUNT_W-1:0] POS_LEN_LOW  = 17'd7;

    localparam logic [16:0] CAPACITY_RESET = 17'h10000;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CFG_FRAME_ID = 2'd0,
        CFG_CAPACITY = 2'd1,
        CFG_KEEP     = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_CHECK  = 3'd3,
        ST_OVER_CAP   = 3'd4
    } status_t;

    // One result item as it travels from the front end to the output stage.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        status_t     status;
        logic [10:0] apid;
        logic [1:0]  grid;
        logic [13:0] nul;
        logic [15:0] count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/dfdc_front.sv =====
`default_nettype none
`include "assert_macros.svh"

module dfdc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [16:0]       cfg_data,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output logic                   push,
    output dfdc_pkg::result_t      result
);

    logic [15:0] frame_id_reg;
    logic [16:0] capacity_reg;
    logic        keep_reg;

    logic [dfdc_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [15:0] recv_check_reg, recv_check_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic        id_match_reg, id_match_next;
    logic [10:0] apid_reg, apid_next;
    logic [1:0]  grid_reg, grid_next;
    logic [13:0] nul_reg, nul_next;
    logic [15:0] length_reg, length_next;

    logic [15:0] sum_now;
    logic [15:0] check_now;
    logic [15:0] word;
    logic [15:0] pay_count;
    logic [17:0] frame_len;
    logic [17:0] expect_len;
    logic [17:0] pay_end;
    logic        in_payload;
    dfdc_pkg::status_t status;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_id_reg <= '0;
            capacity_reg <= dfdc_pkg::CAPACITY_RESET;
            keep_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (dfdc_pkg::cfg_index_t'(cfg_index))
                dfdc_pkg::CFG_FRAME_ID: frame_id_reg <= cfg_data[15:0];
                dfdc_pkg::CFG_CAPACITY: capacity_reg <= cfg_data;
                dfdc_pkg::CFG_KEEP:     keep_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The checksum lags two bytes so that the trailer never adds itself in.
    assign sum_now    = running_sum_reg + {8'h00, recv_check_reg[15:8]};
    assign check_now  = {recv_check_reg[7:0], in_byte};
    assign word       = {high_byte_reg, in_byte};
    assign pay_count  = length_reg + 16'd1;
    assign frame_len  = {1'b0, byte_count_reg} + 18'd1;
    assign expect_len = {2'b00, pay_count} + 18'(dfdc_pkg::MIN_FRAME);
    assign pay_end    = {2'b00, pay_count} + 18'(dfdc_pkg::HDR_BYTES);
    assign in_payload = keep_reg
                     && ({1'b0, byte_count_reg} >= 18'(dfdc_pkg::HDR_BYTES))
                     && ({1'b0, byte_count_reg} < pay_end);

    always_comb begin
        if (frame_len < 18'(dfdc_pkg::MIN_FRAME)) begin
            status = dfdc_pkg::ST_BAD_LENGTH;
        end else if (!id_match_reg) begin
            status = dfdc_pkg::ST_BAD_ID;
        end else if (frame_len != expect_len) begin
            status = dfdc_pkg::ST_BAD_LENGTH;
        end else if (sum_now != check_now) begin
            status = dfdc_pkg::ST_BAD_CHECK;
        end else if (keep_reg && (capacity_reg < {1'b0, pay_count})) begin
            status = dfdc_pkg::ST_OVER_CAP;
        end else begin
            status = dfdc_pkg::ST_OK;
        end
    end

    always_comb begin
        result = '0;
        push   = 1'b0;
        if (accept && in_last) begin
            push          = 1'b1;
            result.kind   = 1'b1;
            result.status = status;
            // A short frame reports no header fields.
            if (frame_len >= 18'(dfdc_pkg::MIN_FRAME)) begin
                result.apid  = apid_reg & dfdc_pkg::APID_MASK;
                result.grid  = grid_reg;
                result.nul   = nul_reg;
                result.count = pay_count;
            end
        end else if (accept && in_payload) begin
            push        = 1'b1;
            result.data = in_byte;
        end
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        recv_check_next  = recv_check_reg;
        high_byte_next   = high_byte_reg;
        id_match_next    = id_match_reg;
        apid_next        = apid_reg;
        grid_next        = grid_reg;
        nul_next         = nul_reg;
        length_next      = length_reg;
        if (accept) begin
            if (in_last) begin
                byte_count_next  = '0;
                running_sum_next = '0;
                recv_check_next  = '0;
                high_byte_next   = '0;
                id_match_next    = 1'b0;
                apid_next        = '0;
                grid_next        = '0;
                nul_next         = '0;
                length_next      = '0;
            end else begin
                running_sum_next = sum_now;
                recv_check_next  = check_now;
                high_byte_next   = in_byte;
                if (byte_count_reg != dfdc_pkg::COUNT_MAX) begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
                unique case (byte_count_reg)
                    dfdc_pkg::POS_ID_LOW:   id_match_next = (word == frame_id_reg);
                    dfdc_pkg::POS_APID_LOW: apid_next = word[10:0] & dfdc_pkg::APID_MASK;
                    dfdc_pkg::POS_GRID:     grid_next = in_byte[7:6];
                    dfdc_pkg::POS_NUL_LOW:
                        nul_next = {high_byte_reg[5:0] & dfdc_pkg::NUL_HIGH_MASK, in_byte};
                    dfdc_pkg::POS_LEN_LOW:  length_next = word;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            recv_check_reg  <= '0;
            high_byte_reg   <= '0;
            id_match_reg    <= 1'b0;
            apid_reg        <= '0;
            grid_reg        <= '0;
            nul_reg         <= '0;
            length_reg      <= '0;
        end else begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            recv_check_reg  <= recv_check_next;
            high_byte_reg   <= high_byte_next;
            id_match_reg    <= id_match_next;
            apid_reg        <= apid_next;
            grid_reg        <= grid_next;
            nul_reg         <= nul_next;
            length_reg      <= length_next;
        end
    end

    `DFDC_ASSERT(a_frame_restart, accept && in_last |=> byte_count_reg == '0 && recv_check_reg == '0, "frame state not cleared after end byte")

endmodule

`default_nettype wire

// ===== hdl/dfdc_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module dfdc_queue #(
    parameter int unsigned DEPTH = dfdc_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dfdc_pkg::result_t push_item,
    input  wire logic              pop,
    output dfdc_pkg::result_t      head_item,
    output logic                   not_empty,
    output logic                   full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dfdc_pkg::result_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    `DFDC_ASSERT(a_no_overflow, push |-> !full || pop, "item pushed into a full queue")
    `DFDC_ASSERT(a_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "lost item")

endmodule

`default_nettype wire

// ===== hdl/dfdc_back.sv =====
`default_nettype none

module dfdc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_not_empty,
    input  wire dfdc_pkg::result_t q_head,
    output logic                   q_pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output dfdc_pkg::result_t      out_item
);

    logic              valid_reg, valid_next;
    dfdc_pkg::result_t item_reg;

    // Refill the output register whenever it is empty or being taken.
    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/data_frame_deframer_checker_core.sv =====
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// A result item is written into the queue and then into the output register before it appears on the m_ channel.
// The front end updates the frame state at the accepting edge; a small queue and an output
// register follow it, so the input side stalls only once the queue holds QUEUE_DEPTH items.
// Reset: aresetn is synchronous and active low; it clears the frame state, the queue and the
// output register, and restores the configuration registers to their defaults.
`default_nettype none

module data_frame_deframer_checker_core #(
    parameter int unsigned QUEUE_DEPTH = dfdc_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port. Index 0 is the frame identifier, 1 the payload
    // capacity and 2 the keep-payload flag; other indexes are ignored.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,

    // Input byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_in
    input  wire logic        s_tlast,   // end_of_frame

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] data_out, [10:8] status, [21:11] apid_out,
                                        // [23:22] grid_out, [37:24] nul_out,
                                        // [53:38] payload_count, [55:54] zero
    output logic             m_tuser    // kind: 0 payload byte, 1 frame status
);

    logic              accept;
    logic              push;
    dfdc_pkg::result_t push_item;
    logic              q_pop;
    logic              q_not_empty;
    logic              q_full;
    dfdc_pkg::result_t q_head;
    dfdc_pkg::result_t out_item;

    // The input side is held off only when the queue has no room for the
    // item that this byte might produce.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Front end: configuration, frame parsing, checksum and the status decision.
    dfdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .result    (push_item)
    );

    // Short queue between the parser and the output stage.
    dfdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Back end: the registered output stage of the result channel.
    dfdc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_item    (out_item)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {2'b00, out_item.count, out_item.nul, out_item.grid,
                      out_item.apid, out_item.status, out_item.data};
    assign m_tuser = out_item.kind;

endmodule

`default_nettype wire
